/* design/roulette_wheel_selection_defines.svh */
// Assertion macros shared by the roulette wheel selection block.
`ifndef ROULETTE_WHEEL_SELECTION_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RWS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("roulette wheel selection: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("roulette wheel selection: next-cycle check failed");

`endif

/* design/rws_pkg.sv */
`default_nettype none

package rws_pkg;

    localparam int POP_SIZE_DEF     = 256;
    localparam int FITNESS_BITS_DEF = 16;

    localparam int FRAC_W   = 16;
    localparam int FRAC_ONE = 65535;
    localparam int INDEX_W  = 8;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZERO  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

`default_nettype wire

/* design/rws_mem.sv */
`default_nettype none

module rws_mem #(
    parameter int DEPTH  = rws_pkg::POP_SIZE_DEF,
    parameter int DATA_W = rws_pkg::FITNESS_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [DATA_W-1:0]         i_wdata,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [DATA_W-1:0]         o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/rws_mul.sv */
`default_nettype none

module rws_mul #(
    parameter int TOTAL_W = rws_pkg::FITNESS_BITS_DEF + 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire  [rws_pkg::FRAC_W-1:0]         i_frac,
    input  wire  [TOTAL_W-1:0]                 i_total,
    output logic                               o_done,
    output logic [TOTAL_W+rws_pkg::FRAC_W-1:0] o_product
);

    localparam int PW    = TOTAL_W + rws_pkg::FRAC_W;
    localparam int CNT_W = $clog2(rws_pkg::FRAC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rws_pkg::FRAC_W - 1);

    logic [PW-1:0]              r_acc;
    logic [rws_pkg::FRAC_W-1:0] r_frac;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Most significant fraction bit first: one shift and add per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= '0;
            r_frac <= i_frac;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_acc  <= (r_acc << 1) +
                      (r_frac[rws_pkg::FRAC_W-1] ? PW'(i_total) : PW'(0));
            r_frac <= r_frac << 1;
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

/* design/roulette_wheel_selection.sv */
// Roulette wheel selection. A load beat (cmd 0) stores one fitness value at the next free
// slot of an on-chip table and adds it to a running total; with first set the table is
// emptied beforehand, and a load into a full table is dropped and answered with status 3
// through the result state and the output register. A successful load gives no result,
// and the input stays ready. A select beat (cmd 1) is answered through the same path with
// status 1 (empty table) or 2 (zero total); otherwise it forms random_fraction * total
// with a shift-add multiplier, then streams the table through its single read port, one
// entry per cycle, and returns the first index whose cumulative fitness reaches
// floor(random_fraction * total / 65535). The input is ready again in the same cycle
// that a result is presented. One item is in work at a time; a finished result waits
// in the output register while the next beat is taken.
`default_nettype none

`include "roulette_wheel_selection_defines.svh"

module roulette_wheel_selection #(
    parameter int POP_SIZE     = rws_pkg::POP_SIZE_DEF,
    parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_cmd,
    input  wire                               i_first,
    input  wire  [15:0]                       i_fitness,
    input  wire  [rws_pkg::FRAC_W-1:0]        i_random_fraction,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [rws_pkg::INDEX_W-1:0]       o_selected_index,
    output logic [1:0]                        o_status
);

    localparam int AW      = $clog2(POP_SIZE);
    localparam int CW      = $clog2(POP_SIZE + 1);
    localparam int TOTAL_W = FITNESS_BITS + AW;
    localparam int PW      = TOTAL_W + rws_pkg::FRAC_W;
    localparam logic [PW-1:0] TGT_BIAS = PW'(rws_pkg::FRAC_ONE - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(POP_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_WALK,
        S_RESULT
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [TOTAL_W-1:0]           r_total, n_total;
    logic [PW-1:0]                r_target, n_target;
    logic [PW-1:0]                r_scaled, n_scaled;
    logic [CW-1:0]                r_raddr, n_raddr;
    logic                         r_v1, n_v1;
    logic [AW-1:0]                r_i1, n_i1;
    logic                         r_v2, n_v2;
    logic [AW-1:0]                r_i2, n_i2;
    logic [rws_pkg::INDEX_W-1:0]  r_res_idx, n_res_idx;
    rws_pkg::t_status             r_res_status, n_res_status;
    logic                         r_o_valid, n_o_valid;
    logic [rws_pkg::INDEX_W-1:0]  r_o_idx, n_o_idx;
    rws_pkg::t_status             r_o_status, n_o_status;

    logic                    accept;
    logic [CW-1:0]           eff_count;
    logic [TOTAL_W-1:0]      eff_total;
    logic [FITNESS_BITS-1:0] load_value;
    logic                    mem_we;
    logic                    mem_re;
    logic [FITNESS_BITS-1:0] mem_rdata;
    logic [PW-1:0]           mem_scaled;
    logic                    mul_start;
    logic                    mul_done;
    logic [PW-1:0]           mul_product;

    assign accept     = i_in_valid && o_in_ready;
    assign eff_count  = i_first ? '0 : r_count;
    assign eff_total  = i_first ? '0 : r_total;
    assign load_value = FITNESS_BITS'(i_fitness);
    assign mem_we     = accept && (i_cmd == rws_pkg::CMD_LOAD) && (eff_count < COUNT_MAX);
    assign mem_re     = (r_state == S_WALK) && (r_raddr < r_count);
    assign mul_start  = accept && (i_cmd == rws_pkg::CMD_SELECT) &&
                        (r_count != '0) && (r_total != '0);
    assign mem_scaled = PW'({mem_rdata, {rws_pkg::FRAC_W{1'b0}}}) - PW'(mem_rdata);

    rws_mem #(
        .DEPTH  (POP_SIZE),
        .DATA_W (FITNESS_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (eff_count[AW-1:0]),
        .i_wdata (load_value),
        .i_re    (mem_re),
        .i_raddr (r_raddr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    rws_mul #(
        .TOTAL_W (TOTAL_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_frac    (i_random_fraction),
        .i_total   (r_total),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_target     = r_target;
        n_scaled     = r_scaled;
        n_raddr      = r_raddr;
        n_v1         = 1'b0;
        n_i1         = r_i1;
        n_v2         = 1'b0;
        n_i2         = r_i2;
        n_res_idx    = r_res_idx;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_idx      = r_o_idx;
        n_o_status   = r_o_status;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_idx = '0;
                    if (i_cmd == rws_pkg::CMD_LOAD) begin
                        n_count = eff_count;
                        n_total = eff_total;
                        if (eff_count >= COUNT_MAX) begin
                            n_res_status = rws_pkg::ST_FULL;
                            n_state      = S_RESULT;
                        end else begin
                            n_count = eff_count + CW'(1);
                            n_total = eff_total + TOTAL_W'(load_value);
                        end
                    end else if (r_count == '0) begin
                        n_res_status = rws_pkg::ST_EMPTY;
                        n_state      = S_RESULT;
                    end else if (r_total == '0) begin
                        n_res_status = rws_pkg::ST_ZERO;
                        n_state      = S_RESULT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    // Running sum reaches the threshold exactly when
                    // 65535 * sum >= product - 65534.
                    n_target = (mul_product >= TGT_BIAS) ? mul_product - TGT_BIAS : '0;
                    n_scaled = '0;
                    n_raddr  = '0;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                n_v1 = mem_re;
                n_i1 = r_raddr[AW-1:0];
                if (mem_re) begin
                    n_raddr = r_raddr + CW'(1);
                end
                n_v2 = r_v1;
                if (r_v1) begin
                    n_scaled = r_scaled + mem_scaled;
                    n_i2     = r_i1;
                end
                if (r_v2 && ((r_scaled >= r_target) ||
                             (CW'(r_i2) == r_count - CW'(1)))) begin
                    n_res_idx    = rws_pkg::INDEX_W'(r_i2);
                    n_res_status = rws_pkg::ST_OK;
                    n_v1         = 1'b0;
                    n_v2         = 1'b0;
                    n_state      = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_idx    = r_res_idx;
                    n_o_status = r_res_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_total   <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_total   <= n_total;
            r_v1      <= n_v1;
            r_v2      <= n_v2;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target     <= n_target;
        r_scaled     <= n_scaled;
        r_raddr      <= n_raddr;
        r_i1         <= n_i1;
        r_i2         <= n_i2;
        r_res_idx    <= n_res_idx;
        r_res_status <= n_res_status;
        r_o_idx      <= n_o_idx;
        r_o_status   <= n_o_status;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_selected_index = r_o_idx;
    assign o_status         = r_o_status;

    `RWS_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= COUNT_MAX)
    `RWS_ASSERT_IMPL(a_mul_done_state, i_clk, i_rst_n, mul_done, r_state == S_MUL)
    `RWS_ASSERT_IMPL(a_walk_nonzero, i_clk, i_rst_n, r_state == S_WALK,
        (r_total != '0) && (r_count != '0))
    `RWS_ASSERT_IMPL(a_fail_index_zero, i_clk, i_rst_n,
        o_out_valid && (o_status != rws_pkg::ST_OK), o_selected_index == '0)
    `RWS_ASSERT_NEXT(a_result_to_idle, i_clk, i_rst_n,
        (r_state == S_RESULT) && (!r_o_valid || i_out_ready), o_out_valid && o_in_ready)

endmodule

`default_nettype wire
